// ===== sv/lpd_pkg.sv =====
package lpd_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_ANGLE_CENTER   = 3'd0;
  localparam logic [2:0] REG_ACCEL_THRESH   = 3'd1;
  localparam logic [2:0] REG_STILL_LIMIT    = 3'd2;
  localparam logic [2:0] REG_SPIN_THRESH    = 3'd3;
  localparam logic [2:0] REG_STILL_TICKS    = 3'd4;
  localparam logic [2:0] REG_JOLT_WINDOW    = 3'd5;
  localparam logic [2:0] REG_SPIN_WINDOW    = 3'd6;
  localparam logic [2:0] REG_PLACE_WINDOW   = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // reset values of the registers
  localparam logic signed [14:0] RST_ANGLE_CENTER = 15'sd0;
  localparam logic [14:0] RST_ACCEL_THRESH = 15'd26000;
  localparam logic [15:0] RST_STILL_LIMIT  = 16'd30;
  localparam logic [15:0] RST_SPIN_THRESH  = 16'd135;
  localparam logic [7:0]  RST_STILL_TICKS  = 8'd10;
  localparam logic [11:0] RST_JOLT_WINDOW  = 12'd200;
  localparam logic [11:0] RST_SPIN_WINDOW  = 12'd100;
  localparam logic [11:0] RST_PLACE_WINDOW = 12'd50;

  // angle spans around the upright center, 1/100 deg
  localparam logic signed [17:0] JOLT_SPAN = 18'sd2000;
  localparam logic signed [17:0] REST_SPAN = 18'sd1000;

  // hand turn window, both wheels strictly inside
  localparam logic signed [15:0] HAND_MIN = -16'sd60;
  localparam logic signed [15:0] HAND_MAX = -16'sd3;

  typedef struct packed {
    logic signed [14:0] angle_center;
    logic [14:0]        lift_accel_threshold;
    logic [15:0]        still_speed_limit;
    logic [15:0]        spin_speed_threshold;
    logic [7:0]         still_ticks;
    logic [11:0]        jolt_window_ticks;
    logic [11:0]        spin_window_ticks;
    logic [11:0]        place_window_ticks;
  } cfg_t;

  typedef enum logic [1:0] {
    LIFT_STILL = 2'd0,
    LIFT_JOLT  = 2'd1,
    LIFT_SPIN  = 2'd2
  } lift_phase_t;

  typedef enum logic {
    PLACE_REST = 1'b0,
    PLACE_TURN = 1'b1
  } place_phase_t;

  // magnitude of a signed 16 bit value
  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    logic signed [16:0] x;
    begin
      x = {v[15], v};
      abs16 = x[16] ? 17'(-x) : 17'(x);
    end
  endfunction

  // tilt strictly inside center +/- span
  function automatic logic in_window(input logic signed [15:0] tilt,
                                     input logic signed [14:0] center,
                                     input logic signed [17:0] span);
    logic signed [17:0] t;
    logic signed [17:0] c;
    begin
      t = {{2{tilt[15]}}, tilt};
      c = {{3{center[14]}}, center};
      in_window = (t > c - span) && (t < c + span);
    end
  endfunction

endpackage

// ===== sv/lift_and_place_detector.sv =====
// channel   signals                                              dir  transfer when
// item      item_valid item_stall wheel_left wheel_right         in   valid && !stall
//           accel_vertical tilt stopped_in
// result    result_valid result_stall lift_seen place_seen       out  valid && !stall
//           stopped_out
// config    cfg_valid cfg_ready cfg_index cfg_data               in   valid && ready
//
// one tick per cycle sustained while result_stall stays low; an item passes the input
// register, then the result register, and result_valid rises when it moves into the
// result register; all detection is one pass of compares and counter increments
// between the two registers
// detector state updates when an item moves into the result register, so the
// next item sees it without a bubble
// rst is synchronous: config returns to defaults, both detectors to their first phase
// a held result_stall backs up into item_stall once the input register is also full
module lift_and_place_detector (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  logic signed [15:0]              wheel_left,
  input  logic signed [15:0]              wheel_right,
  input  logic signed [15:0]              accel_vertical,
  input  logic signed [15:0]              tilt,
  input  logic                            stopped_in,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            lift_seen,
  output logic                            place_seen,
  output logic                            stopped_out,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lpd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lpd_pkg::*;

  cfg_t cfg;

  logic               s1_valid;
  logic signed [15:0] s1_wheel_left;
  logic signed [15:0] s1_wheel_right;
  logic signed [15:0] s1_accel;
  logic signed [15:0] s1_tilt;
  logic               s1_stopped;

  logic advance, take_in, fire;
  logic lift, place, stopped_mid;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;
  assign take_in    = item_valid && !item_stall;
  assign fire       = s1_valid && advance;

  lpd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpd_lift u_lift (
    .clk            (clk),
    .rst            (rst),
    .en             (fire),
    .cfg            (cfg),
    .wheel_left     (s1_wheel_left),
    .wheel_right    (s1_wheel_right),
    .accel_vertical (s1_accel),
    .tilt           (s1_tilt),
    .lift           (lift)
  );

  // place detector sees the stop flag after this tick's lift
  assign stopped_mid = s1_stopped | lift;

  lpd_place u_place (
    .clk         (clk),
    .rst         (rst),
    .en          (fire),
    .cfg         (cfg),
    .stopped     (stopped_mid),
    .wheel_left  (s1_wheel_left),
    .wheel_right (s1_wheel_right),
    .tilt        (s1_tilt),
    .place       (place)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_wheel_left  <= wheel_left;
      s1_wheel_right <= wheel_right;
      s1_accel       <= accel_vertical;
      s1_tilt        <= tilt;
      s1_stopped     <= stopped_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lift_seen   <= lift;
      place_seen  <= place;
      stopped_out <= stopped_mid & ~place;
    end
  end

`ifndef ASSERT_OFF
  a_place_clears: assert property (@(posedge clk) disable iff (rst)
    result_valid && place_seen |-> !stopped_out)
    else $error("put-down left the stop flag set");
  a_lift_sets: assert property (@(posedge clk) disable iff (rst)
    result_valid && lift_seen && !place_seen |-> stopped_out)
    else $error("lift did not set the stop flag");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== sv/lpd_cfg.sv =====
module lpd_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lpd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output lpd_pkg::cfg_t                       cfg
);
  import lpd_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.angle_center         <= RST_ANGLE_CENTER;
      cfg.lift_accel_threshold <= RST_ACCEL_THRESH;
      cfg.still_speed_limit    <= RST_STILL_LIMIT;
      cfg.spin_speed_threshold <= RST_SPIN_THRESH;
      cfg.still_ticks          <= RST_STILL_TICKS;
      cfg.jolt_window_ticks    <= RST_JOLT_WINDOW;
      cfg.spin_window_ticks    <= RST_SPIN_WINDOW;
      cfg.place_window_ticks   <= RST_PLACE_WINDOW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ANGLE_CENTER: cfg.angle_center         <= $signed(cfg_data[14:0]);
        REG_ACCEL_THRESH: cfg.lift_accel_threshold <= cfg_data[14:0];
        REG_STILL_LIMIT:  cfg.still_speed_limit    <= cfg_data;
        REG_SPIN_THRESH:  cfg.spin_speed_threshold <= cfg_data;
        REG_STILL_TICKS:  cfg.still_ticks          <= cfg_data[7:0];
        REG_JOLT_WINDOW:  cfg.jolt_window_ticks    <= cfg_data[11:0];
        REG_SPIN_WINDOW:  cfg.spin_window_ticks    <= cfg_data[11:0];
        REG_PLACE_WINDOW: cfg.place_window_ticks   <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/lpd_lift.sv =====
module lpd_lift (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  lpd_pkg::cfg_t        cfg,
  input  logic signed [15:0]   wheel_left,
  input  logic signed [15:0]   wheel_right,
  input  logic signed [15:0]   accel_vertical,
  input  logic signed [15:0]   tilt,
  output logic                 lift
);
  import lpd_pkg::*;

  lift_phase_t phase, phase_next;
  logic [7:0]  still_count, still_count_next;
  logic [11:0] jolt_count, jolt_count_next;
  logic [11:0] spin_count, spin_count_next;
  logic        spin_eval;

  logic [17:0]        speed_sum;
  logic signed [17:0] wheel_sum;
  logic [17:0]        spin_mag;
  logic               is_still, is_jolt, is_spin;
  logic [8:0]         still_inc;
  logic [12:0]        jolt_inc, spin_inc;

  assign speed_sum = {1'b0, abs16(wheel_left)} + {1'b0, abs16(wheel_right)};
  assign is_still  = speed_sum < {2'b00, cfg.still_speed_limit};
  assign is_jolt   = ($signed({accel_vertical[15], accel_vertical}) >
                      $signed({2'b00, cfg.lift_accel_threshold})) &&
                     in_window(tilt, cfg.angle_center, JOLT_SPAN);
  assign wheel_sum = {{2{wheel_left[15]}}, wheel_left} +
                     {{2{wheel_right[15]}}, wheel_right};
  assign spin_mag  = wheel_sum[17] ? 18'(-wheel_sum) : 18'(wheel_sum);
  assign is_spin   = spin_mag > {2'b00, cfg.spin_speed_threshold};

  // phases chain within one tick: still -> jolt -> spin
  always_comb begin
    phase_next       = phase;
    still_count_next = still_count;
    jolt_count_next  = jolt_count;
    spin_count_next  = spin_count;
    spin_eval        = 1'b0;
    still_inc        = '0;
    jolt_inc         = '0;
    spin_inc         = '0;
    if (phase_next == LIFT_STILL) begin
      still_inc = is_still ? {1'b0, still_count} + 9'd1 : 9'd0;
      if (still_inc > {1'b0, cfg.still_ticks}) begin
        phase_next = LIFT_JOLT;
        still_inc  = '0;
      end
      still_count_next = still_inc[7:0];
    end
    if (phase_next == LIFT_JOLT) begin
      jolt_inc = {1'b0, jolt_count} + 13'd1;
      if (jolt_inc > {1'b0, cfg.jolt_window_ticks}) begin
        jolt_inc   = '0;
        phase_next = LIFT_STILL;
      end
      jolt_count_next = jolt_inc[11:0];
      if (is_jolt) begin
        phase_next = LIFT_SPIN;
      end
    end
    if (phase_next == LIFT_SPIN) begin
      spin_inc = {1'b0, spin_count} + 13'd1;
      if (spin_inc > {1'b0, cfg.spin_window_ticks}) begin
        spin_inc   = '0;
        phase_next = LIFT_STILL;
      end
      spin_count_next = spin_inc[11:0];
      spin_eval       = 1'b1;
      if (is_spin) begin
        phase_next = LIFT_STILL;
      end
    end
  end

  always_comb begin
    lift = spin_eval && is_spin;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= LIFT_STILL;
      still_count <= '0;
      jolt_count  <= '0;
      spin_count  <= '0;
    end else if (en) begin
      phase       <= phase_next;
      still_count <= still_count_next;
      jolt_count  <= jolt_count_next;
      spin_count  <= spin_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_lift_rearms: assert property (@(posedge clk) disable iff (rst)
    en && lift |=> phase == LIFT_STILL)
    else $error("lift reported but detector not back to stillness");
  a_lift_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(phase) && $stable(still_count) && $stable(spin_count))
    else $error("lift state moved without a tick");
`endif

endmodule

// ===== sv/lpd_place.sv =====
module lpd_place (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  lpd_pkg::cfg_t        cfg,
  input  logic                 stopped,
  input  logic signed [15:0]   wheel_left,
  input  logic signed [15:0]   wheel_right,
  input  logic signed [15:0]   tilt,
  output logic                 place
);
  import lpd_pkg::*;

  place_phase_t phase, phase_next;
  logic [11:0]  place_count, place_count_next;
  logic [12:0]  place_inc;
  logic         turn_eval;
  logic         is_rest, is_turn;

  assign is_rest = in_window(tilt, cfg.angle_center, REST_SPAN) &&
                   (wheel_left == 16'sd0) && (wheel_right == 16'sd0);
  assign is_turn = (wheel_left < HAND_MAX) && (wheel_right < HAND_MAX) &&
                   (wheel_left > HAND_MIN) && (wheel_right > HAND_MIN);

  always_comb begin
    phase_next       = phase;
    place_count_next = place_count;
    place_inc        = '0;
    turn_eval        = 1'b0;
    if (stopped) begin
      if (phase_next == PLACE_REST && is_rest) begin
        phase_next = PLACE_TURN;
      end
      if (phase_next == PLACE_TURN) begin
        place_inc = {1'b0, place_count} + 13'd1;
        if (place_inc > {1'b0, cfg.place_window_ticks}) begin
          place_inc  = '0;
          phase_next = PLACE_REST;
        end
        place_count_next = place_inc[11:0];
        turn_eval        = 1'b1;
        if (is_turn) begin
          phase_next = PLACE_REST;
        end
      end
    end
  end

  always_comb begin
    place = turn_eval && is_turn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PLACE_REST;
      place_count <= '0;
    end else if (en) begin
      phase       <= phase_next;
      place_count <= place_count_next;
    end
  end

`ifndef ASSERT_OFF
  a_place_needs_stop: assert property (@(posedge clk) disable iff (rst)
    place |-> stopped)
    else $error("put-down reported while not stopped");
  a_place_idle_running: assert property (@(posedge clk) disable iff (rst)
    en && !stopped |=> $stable(phase) && $stable(place_count))
    else $error("place detector moved while motors running");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lpd_pkg::*;

  typedef struct {
    logic signed [15:0] wl;
    logic signed [15:0] wr;
    logic signed [15:0] acc;
    logic signed [15:0] tilt;
    logic               stp;
  } tick_t;

  typedef struct {
    logic lift;
    logic place;
    logic stopped;
  } flags_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           item_valid = 1'b0;
  logic                           item_stall;
  logic signed [15:0]             wheel_left = '0;
  logic signed [15:0]             wheel_right = '0;
  logic signed [15:0]             accel_vertical = '0;
  logic signed [15:0]             tilt = '0;
  logic                           stopped_in = 1'b0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic                           lift_seen;
  logic                           place_seen;
  logic                           stopped_out;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [CFG_INDEX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]          cfg_data = '0;

  lift_and_place_detector dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .wheel_left     (wheel_left),
    .wheel_right    (wheel_right),
    .accel_vertical (accel_vertical),
    .tilt           (tilt),
    .stopped_in     (stopped_in),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .lift_seen      (lift_seen),
    .place_seen     (place_seen),
    .stopped_out    (stopped_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // tracked copy of the detector configuration and state
  cfg_t         track_cfg;
  lift_phase_t  trk_lift_phase;
  logic [7:0]   trk_still_cnt;
  logic [11:0]  trk_jolt_cnt;
  logic [11:0]  trk_spin_cnt;
  place_phase_t trk_place_phase;
  logic [11:0]  trk_place_cnt;

  tick_t  ticks_to_send[$];
  flags_t expected_flags[$];
  tick_t  cur_tick;
  int     ticks_accepted = 0;
  int     gap_left = 0;
  int     stall_left = 0;
  int     mismatches = 0;
  bit     idle_on = 1'b1;
  logic   long_hold = 1'b0;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int pick(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one control tick through both detectors
  function automatic flags_t advance_detector(input tick_t t);
    int     wl, wr, acc, tl, ctr, n;
    flags_t r;
    wl = t.wl;
    wr = t.wr;
    acc = t.acc;
    tl = t.tilt;
    ctr = $signed(track_cfg.angle_center);
    r.lift = 1'b0;
    r.place = 1'b0;
    r.stopped = t.stp;

    if (trk_lift_phase == LIFT_STILL) begin
      if (mag(wl) + mag(wr) < int'(track_cfg.still_speed_limit))
        n = int'(trk_still_cnt) + 1;
      else
        n = 0;
      if (n > int'(track_cfg.still_ticks)) begin
        trk_lift_phase = LIFT_JOLT;
        n = 0;
      end
      trk_still_cnt = n[7:0];
    end
    if (trk_lift_phase == LIFT_JOLT) begin
      n = int'(trk_jolt_cnt) + 1;
      if (n > int'(track_cfg.jolt_window_ticks)) begin
        n = 0;
        trk_lift_phase = LIFT_STILL;
      end
      trk_jolt_cnt = n[11:0];
      // jolt test still runs on the tick that timed out
      if (acc > int'(track_cfg.lift_accel_threshold) &&
          tl > ctr - int'(JOLT_SPAN) && tl < ctr + int'(JOLT_SPAN))
        trk_lift_phase = LIFT_SPIN;
    end
    if (trk_lift_phase == LIFT_SPIN) begin
      n = int'(trk_spin_cnt) + 1;
      if (n > int'(track_cfg.spin_window_ticks)) begin
        n = 0;
        trk_lift_phase = LIFT_STILL;
      end
      trk_spin_cnt = n[11:0];
      if (mag(wl + wr) > int'(track_cfg.spin_speed_threshold)) begin
        trk_lift_phase = LIFT_STILL;
        r.lift = 1'b1;
      end
    end
    if (r.lift)
      r.stopped = 1'b1;

    if (r.stopped) begin
      if (trk_place_phase == PLACE_REST && wl == 0 && wr == 0 &&
          tl > ctr - int'(REST_SPAN) && tl < ctr + int'(REST_SPAN))
        trk_place_phase = PLACE_TURN;
      if (trk_place_phase == PLACE_TURN) begin
        n = int'(trk_place_cnt) + 1;
        if (n > int'(track_cfg.place_window_ticks)) begin
          n = 0;
          trk_place_phase = PLACE_REST;
        end
        trk_place_cnt = n[11:0];
        if (wl < int'(HAND_MAX) && wr < int'(HAND_MAX) &&
            wl > int'(HAND_MIN) && wr > int'(HAND_MIN)) begin
          trk_place_phase = PLACE_REST;
          r.place = 1'b1;
        end
      end
    end
    if (r.place)
      r.stopped = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40)
      $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // sender: one tick per transfer, random gaps between ticks while idle_on is set
  always @(posedge clk) begin : drive_ticks
    logic take;
    take = 1'b0;
    if (item_valid && !item_stall) begin
      expected_flags.push_back(advance_detector(cur_tick));
      ticks_accepted++;
      take = 1'b1;
    end else if (!item_valid) begin
      take = 1'b1;
    end
    if (take) begin
      if (gap_left > 0) begin
        gap_left--;
        item_valid <= 1'b0;
      end else if (ticks_to_send.size() > 0) begin
        cur_tick = ticks_to_send.pop_front();
        wheel_left <= cur_tick.wl;
        wheel_right <= cur_tick.wr;
        accel_vertical <= cur_tick.acc;
        tilt <= cur_tick.tilt;
        stopped_in <= cur_tick.stp;
        item_valid <= 1'b1;
        if (idle_on && $urandom_range(3) == 0)
          gap_left = pick(1, 4);
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // receiver: checks each result transfer, stalls in random bursts while idle_on is set
  always @(posedge clk) begin : check_flags
    flags_t want;
    logic   hold;
    if (result_valid && !result_stall) begin
      if (expected_flags.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_flags.pop_front();
        if (lift_seen !== want.lift)
          report_mismatch($sformatf("lift_seen %b, want %b", lift_seen, want.lift));
        if (place_seen !== want.place)
          report_mismatch($sformatf("place_seen %b, want %b", place_seen, want.place));
        if (stopped_out !== want.stopped)
          report_mismatch($sformatf("stopped_out %b, want %b", stopped_out, want.stopped));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      hold = 1'b1;
    end else if (idle_on && $urandom_range(4) == 0) begin
      stall_left = pick(0, 3);
      hold = 1'b1;
    end else begin
      hold = 1'b0;
    end
    result_stall <= long_hold || hold;
  end

  // long receiver hold-off while ticks keep coming, backs up into item_stall
  initial begin : hold_off
    wait (ticks_accepted >= 140);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (60) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : watchdog
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic push_tick(input int wl, input int wr, input int acc, input int tl,
                           input bit stp);
    tick_t t;
    t.wl = 16'(clip(wl, -32768, 32767));
    t.wr = 16'(clip(wr, -32768, 32767));
    t.acc = 16'(clip(acc, -32768, 32767));
    t.tilt = 16'(clip(tl, -18000, 18000));
    t.stp = stp;
    ticks_to_send.push_back(t);
  endtask

  task automatic still_wheels(output int wl, output int wr);
    int lim, a, b;
    lim = int'(track_cfg.still_speed_limit);
    if (lim <= 1) begin
      wl = 0;
      wr = 0;
    end else begin
      a = pick(0, (lim - 1 > 32767) ? 32767 : lim - 1);
      b = pick(0, (lim - 1 - a > 32767) ? 32767 : lim - 1 - a);
      wl = $urandom_range(1) ? -a : a;
      wr = $urandom_range(1) ? -b : b;
    end
  endtask

  function automatic int low_accel();
    return pick(-32768, int'(track_cfg.lift_accel_threshold));
  endfunction

  function automatic int timeout_len(input int win);
    if (win <= 40 && $urandom_range(4) == 0)
      return win + pick(0, 2);
    return pick(0, 3);
  endfunction

  // still run, jolt near upright, then fast spin; parts go missing now and then
  task automatic add_lift_seq();
    int k, wl, wr, ctr, thr, t;
    ctr = $signed(track_cfg.angle_center);
    k = int'(track_cfg.still_ticks) + 1 + pick(0, 2);
    if ($urandom_range(7) == 0)
      k = pick(0, int'(track_cfg.still_ticks));
    repeat (k) begin
      still_wheels(wl, wr);
      push_tick(wl, wr, low_accel(), pick(-18000, 18000), 1'b0);
    end
    repeat (timeout_len(int'(track_cfg.jolt_window_ticks)))
      push_tick(pick(-5, 5), pick(-5, 5), low_accel(), pick(-18000, 18000), 1'b0);
    if ($urandom_range(7) != 0) begin
      thr = int'(track_cfg.lift_accel_threshold);
      t = ctr + pick(-1999, 1999);
      if ($urandom_range(5) == 0)
        t = ctr + ($urandom_range(1) ? int'(JOLT_SPAN) : -int'(JOLT_SPAN));
      push_tick(pick(-5, 5), pick(-5, 5), (thr < 32767) ? pick(thr + 1, 32767) : 32767,
                t, 1'b0);
    end
    repeat (timeout_len(int'(track_cfg.spin_window_ticks)))
      push_tick(0, 0, pick(-32768, 32767), pick(-18000, 18000), 1'b0);
    if ($urandom_range(7) != 0) begin
      thr = int'(track_cfg.spin_speed_threshold);
      t = thr + 1 + pick(0, 300);
      if (t > 65536)
        t = 65536;
      if ($urandom_range(5) == 0 && thr <= 65534)
        t = thr;
      if (t > 65534 || $urandom_range(1))
        push_tick(-(t - t / 2), -(t / 2), pick(-32768, 32767), pick(-18000, 18000), 1'b0);
      else
        push_tick(t - t / 2, t / 2, pick(-32768, 32767), pick(-18000, 18000), 1'b0);
    end
  endtask

  // upright rest with wheels at zero, then slow backward turn by hand
  task automatic add_place_seq();
    int k, ctr, t, wl, wr;
    ctr = $signed(track_cfg.angle_center);
    k = pick(1, 2);
    repeat (k) begin
      t = ctr + pick(-999, 999);
      if ($urandom_range(5) == 0)
        t = ctr + ($urandom_range(1) ? int'(REST_SPAN) : -int'(REST_SPAN));
      push_tick(0, 0, pick(-32768, 32767), t, 1'b1);
    end
    repeat (timeout_len(int'(track_cfg.place_window_ticks)))
      push_tick(pick(-2, 5), pick(-2, 5), pick(-32768, 32767), pick(-18000, 18000), 1'b1);
    wl = pick(-59, -4);
    wr = pick(-59, -4);
    if ($urandom_range(5) == 0)
      wl = $urandom_range(1) ? int'(HAND_MAX) : int'(HAND_MIN);
    push_tick(wl, wr, pick(-32768, 32767), pick(-18000, 18000), 1'b1);
  endtask

  task automatic fill_random(input int n);
    int start, sel;
    start = ticks_to_send.size() + ticks_accepted;
    while (ticks_to_send.size() + ticks_accepted - start < n) begin
      sel = $urandom_range(9);
      if (sel < 4)
        add_lift_seq();
      else if (sel < 7)
        add_place_seq();
      else
        repeat (pick(1, 5))
          push_tick(pick(-32768, 32767), pick(-32768, 32767), pick(-32768, 32767),
                    pick(-18000, 18000), $urandom_range(1));
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ANGLE_CENTER: track_cfg.angle_center = val[14:0];
      REG_ACCEL_THRESH: track_cfg.lift_accel_threshold = val[14:0];
      REG_STILL_LIMIT:  track_cfg.still_speed_limit = val;
      REG_SPIN_THRESH:  track_cfg.spin_speed_threshold = val;
      REG_STILL_TICKS:  track_cfg.still_ticks = val[7:0];
      REG_JOLT_WINDOW:  track_cfg.jolt_window_ticks = val[11:0];
      REG_SPIN_WINDOW:  track_cfg.spin_window_ticks = val[11:0];
      REG_PLACE_WINDOW: track_cfg.place_window_ticks = val[11:0];
      default: ;
    endcase
  endtask

  task automatic write_cfg(input cfg_t c);
    @(posedge clk);
    write_reg(REG_ANGLE_CENTER, 16'(c.angle_center));
    write_reg(REG_ACCEL_THRESH, 16'(c.lift_accel_threshold));
    write_reg(REG_STILL_LIMIT, c.still_speed_limit);
    write_reg(REG_SPIN_THRESH, c.spin_speed_threshold);
    write_reg(REG_STILL_TICKS, 16'(c.still_ticks));
    write_reg(REG_JOLT_WINDOW, 16'(c.jolt_window_ticks));
    write_reg(REG_SPIN_WINDOW, 16'(c.spin_window_ticks));
    write_reg(REG_PLACE_WINDOW, 16'(c.place_window_ticks));
    cfg_valid <= 1'b0;
  endtask

  function automatic cfg_t phase_cfg(input int p);
    cfg_t c;
    case (p)
      1: begin
        // everything at the easy end, windows at 1 tick
        c.angle_center = 15'(-9000);
        c.lift_accel_threshold = 15'd0;
        c.still_speed_limit = 16'd65535;
        c.spin_speed_threshold = 16'd0;
        c.still_ticks = 8'd1;
        c.jolt_window_ticks = 12'd1;
        c.spin_window_ticks = 12'd1;
        c.place_window_ticks = 12'd1;
      end
      2: begin
        c.angle_center = 15'(9000);
        c.lift_accel_threshold = 15'd32767;
        c.still_speed_limit = 16'd0;
        c.spin_speed_threshold = 16'd65535;
        c.still_ticks = 8'd250;
        c.jolt_window_ticks = 12'd4000;
        c.spin_window_ticks = 12'd4000;
        c.place_window_ticks = 12'd4000;
      end
      3: begin
        // long still run before a lift can start
        c.angle_center = 15'(pick(-9000, 9000));
        c.lift_accel_threshold = 15'd20000;
        c.still_speed_limit = 16'd200;
        c.spin_speed_threshold = 16'd300;
        c.still_ticks = 8'd250;
        c.jolt_window_ticks = 12'd4000;
        c.spin_window_ticks = 12'd4000;
        c.place_window_ticks = 12'd4000;
      end
      default: begin
        c.angle_center = 15'(pick(-3000, 3000));
        c.lift_accel_threshold = 15'(pick(10000, 30000));
        c.still_speed_limit = 16'(pick(5, 120));
        c.spin_speed_threshold = 16'(pick(20, 400));
        c.still_ticks = 8'(pick(1, 12));
        c.jolt_window_ticks = 12'(pick(1, 12));
        c.spin_window_ticks = 12'(pick(1, 12));
        c.place_window_ticks = 12'(pick(1, 12));
      end
    endcase
    return c;
  endfunction

  task automatic drain();
    while (ticks_to_send.size() != 0 || item_valid || expected_flags.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    track_cfg.angle_center = RST_ANGLE_CENTER;
    track_cfg.lift_accel_threshold = RST_ACCEL_THRESH;
    track_cfg.still_speed_limit = RST_STILL_LIMIT;
    track_cfg.spin_speed_threshold = RST_SPIN_THRESH;
    track_cfg.still_ticks = RST_STILL_TICKS;
    track_cfg.jolt_window_ticks = RST_JOLT_WINDOW;
    track_cfg.spin_window_ticks = RST_SPIN_WINDOW;
    track_cfg.place_window_ticks = RST_PLACE_WINDOW;
    trk_lift_phase = LIFT_STILL;
    trk_still_cnt = '0;
    trk_jolt_cnt = '0;
    trk_spin_cnt = '0;
    trk_place_phase = PLACE_REST;
    trk_place_cnt = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed ticks under reset configuration
    push_tick(-32768, -32768, -32768, -18000, 1'b1);
    push_tick(32767, 32767, 32767, 18000, 1'b0);
    push_tick(0, 0, 0, 0, 1'b1);
    push_tick(-3, -60, 0, 0, 1'b1);
    push_tick(-4, -59, 0, 0, 1'b1);
    repeat (11) push_tick(0, 0, 0, 0, 1'b0);
    push_tick(0, 0, 26000, 0, 1'b0);
    push_tick(0, 0, 32767, 2000, 1'b0);
    push_tick(0, 0, 26001, 1999, 1'b0);
    // sum of wheels reaches the full 17 bit magnitude
    push_tick(-32768, -32768, 0, 0, 1'b0);
    push_tick(0, 0, 0, -999, 1'b1);
    push_tick(-10, -10, 0, 0, 1'b1);
    fill_random(220);

    for (int p = 1; p <= 7; p++) begin
      drain();
      write_cfg(phase_cfg(p));
      idle_on = (p != 3 && p != 7);
      fill_random(220);
    end
    drain();
    repeat (8) @(posedge clk);

    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/lpd_pkg.sv
sv/lpd_cfg.sv
sv/lpd_lift.sv
sv/lpd_place.sv
sv/lift_and_place_detector.sv
bench/tb_top.sv
